[rtl/ocrf_pkg.sv]
`timescale 1ns / 1ps

package ocrf_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int COORD_W     = 12;
   localparam int ENTRY_W     = 11;
   localparam int COLOUR_W    = 24;
   localparam int FRAME_W     = 13;
   localparam int SCALE_W     = 20;
   localparam int TRIG_W      = 16;
   localparam int REQ_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_SCALE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS_THETA    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN_THETA    = 3'd4;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_SHADE = 1'b1;

   localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

   typedef struct packed {
      logic                cmd;
      logic [ENTRY_W-1:0]  entry_index;
      logic [COLOUR_W-1:0] entry_colour;
   } item_tag_type;

endpackage

[rtl/octagonal_radius_colour_fill_unit.sv]
`timescale 1ns / 1ps
// A shade request's result item appears after it passes the pipeline and output register.
// Throughput: one item per cycle; the whole pipeline advances together and stalls
// only while a presented result is not taken.
// Reset (synchronous, active high) empties the pipeline and restores the register
// defaults; the colour line memory is not cleared and holds no defined value until loaded.

module octagonal_radius_colour_fill_unit #(
   parameter int LINE_ENTRIES = 1152
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pixel_x, pixel_y, entry_index, entry_colour, zero fill
   input  logic [ocrf_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pixel_colour
   output logic [ocrf_pkg::COLOUR_W-1:0]       rsp_tdata,
   input  logic                                csr_we,
   input  logic [ocrf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ocrf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ocrf_pkg::*;

   localparam int IDX_W   = $clog2(LINE_ENTRIES);
   localparam int STAGES  = 8;

   logic [FRAME_W-1:0]       frame_width_ff, frame_height_ff;
   logic [SCALE_W-1:0]       pixel_scale_ff;
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;

   logic                     advance;
   logic [STAGES-1:0]        valid_ff;
   item_tag_type             tag_ff [STAGES];
   item_tag_type             tag_in;

   logic signed [13:0]       hx_in, hy_in, hx_ff, hy_ff;
   logic signed [34:0]       x_ff, y_ff;
   logic signed [50:0]       xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [51:0]       rx_in, ry_in, rx_ff, ry_ff;
   logic [51:0]              mag_x, mag_y;
   logic [35:0]              ax_ff, ay_ff;
   logic [36:0]              sum_in, sum_ff;
   logic [35:0]              mx_in, mx6_ff, mx7_ff;
   logic [52:0]              diag_prod;
   logic [36:0]              dg_ff;
   logic [36:0]              radius;
   logic [22:0]              line_pos;
   logic [IDX_W-1:0]         radius_addr, addr_in, addr_ff;
   logic                     in_range;
   logic                     rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_W'(320);
         frame_height_ff <= FRAME_W'(240);
         pixel_scale_ff  <= SCALE_W'(65536);
         cos_ff          <= TRIG_W'(32767);
         sin_ff          <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_W-1:0];
            CSR_PIXEL_SCALE:  pixel_scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_COS_THETA:    cos_ff          <= $signed(csr_wdata[TRIG_W-1:0]);
            CSR_SIN_THETA:    sin_ff          <= $signed(csr_wdata[TRIG_W-1:0]);
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance && !reset;

   always_comb begin
      tag_in.cmd          = req_tuser;
      tag_in.entry_index  = req_tdata[34:24];
      tag_in.entry_colour = req_tdata[58:35];
      hx_in = $signed({1'b0, req_tdata[11:0], 1'b0}) - $signed({1'b0, frame_width_ff});
      hy_in = $signed({1'b0, req_tdata[23:12], 1'b0}) - $signed({1'b0, frame_height_ff});
   end

   always_comb begin
      rx_in  = {xc_ff[50], xc_ff} - {ys_ff[50], ys_ff};
      ry_in  = {xs_ff[50], xs_ff} + {yc_ff[50], yc_ff};
      mag_x  = rx_ff[51] ? $unsigned(~rx_ff + 52'sd1) : $unsigned(rx_ff);
      mag_y  = ry_ff[51] ? $unsigned(~ry_ff + 52'sd1) : $unsigned(ry_ff);
      sum_in = {1'b0, ax_ff} + {1'b0, ay_ff};
      mx_in  = (ax_ff > ay_ff) ? ax_ff : ay_ff;
      diag_prod = 53'(sum_ff) * 53'(INV_SQRT2_Q16);
      radius   = ({1'b0, mx7_ff} > dg_ff) ? {1'b0, mx7_ff} : dg_ff;
      line_pos = radius[36:14];
      if (line_pos >= 23'(LINE_ENTRIES)) begin
         radius_addr = IDX_W'(LINE_ENTRIES - 1);
      end else begin
         radius_addr = line_pos[IDX_W-1:0];
      end
      addr_in  = (tag_ff[STAGES-2].cmd == CMD_SHADE) ? radius_addr
                                                     : IDX_W'(tag_ff[STAGES-2].entry_index);
      in_range = {2'b00, tag_ff[STAGES-1].entry_index} < 13'(LINE_ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[STAGES-2:0], req_tvalid};
         rsp_valid_ff <= valid_ff[STAGES-1] && (tag_ff[STAGES-1].cmd == CMD_SHADE);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= tag_in;
         for (int i = 1; i < STAGES; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
         hx_ff  <= hx_in;
         hy_ff  <= hy_in;
         x_ff   <= hx_ff * $signed({1'b0, pixel_scale_ff});
         y_ff   <= hy_ff * $signed({1'b0, pixel_scale_ff});
         xc_ff  <= x_ff * cos_ff;
         ys_ff  <= y_ff * sin_ff;
         xs_ff  <= x_ff * sin_ff;
         yc_ff  <= y_ff * cos_ff;
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         ax_ff  <= mag_x[51:16];
         ay_ff  <= mag_y[51:16];
         sum_ff <= sum_in;
         mx6_ff <= mx_in;
         dg_ff  <= diag_prod[52:16];
         mx7_ff <= mx6_ff;
         addr_ff <= addr_in;
      end
   end

   ocrf_ram #(
      .WIDTH (COLOUR_W),
      .DEPTH (LINE_ENTRIES)
   ) u_colour_line (
      .clock   (clock),
      .wr_en   (advance && valid_ff[STAGES-1] && (tag_ff[STAGES-1].cmd == CMD_LOAD)
                && in_range),
      .wr_addr (addr_ff),
      .wr_data (tag_ff[STAGES-1].entry_colour),
      .rd_en   (advance && valid_ff[STAGES-1] && (tag_ff[STAGES-1].cmd == CMD_SHADE)),
      .rd_addr (addr_ff),
      .rd_data (rsp_tdata)
   );

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/ocrf_ram.sv]
`timescale 1ns / 1ps

module ocrf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1152
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
